// ===== sv/cacfar_pkg.sv =====
// Shared definitions for the cell-averaging CFAR detector: default sizes,
// configuration register map and reset values, and the controller command struct.
// No dependencies.
package cacfar_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_REACH_DEF   = 32;
  localparam int MAX_POINTS_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field and register widths.
  localparam int REACH_CFG_W = 5;
  localparam int SCALE_W     = 16;
  localparam int COUNT_W     = 13;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // Register reset values.
  localparam logic [REACH_CFG_W-1:0] GUARD_RST  = 5'd2;
  localparam logic [REACH_CFG_W-1:0] REF_RST    = 5'd8;
  localparam logic [SCALE_W-1:0]     SCALE_RST  = 16'd1280;
  localparam logic [COUNT_W-1:0]     MAXDET_RST = 13'd4096;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GUARD  = 2'd0,
    CFG_REF    = 2'd1,
    CFG_SCALE  = 2'd2,
    CFG_MAXDET = 2'd3
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;       // write the accepted sample into the window
    logic rd;         // read one tap pair
    logic rd_first;   // the left read is the cell under test itself
    logic rd_left;    // left tap lies inside the frame
    logic rd_right;   // right tap lies inside the frame
    logic mul;        // load the two products
    logic judge;      // load the verdict into the output register
    logic frame_end;  // verdict belongs to the frame's last cell on a flush
  } dp_cmd_t;

endpackage

// ===== sv/ca_cfar_detector_core.sv =====
// Top level of the one-dimensional cell-averaging CFAR detector: configuration
// registers, controller and datapath. Depends on cacfar_pkg, cacfar_ctrl, cacfar_dp.
//
// Usage. Power samples of a frame enter on the input channel (in_valid, in_stall,
// power, frame_last), one request per range bin. Verdicts leave on the output
// channel (out_valid, out_stall and the verdict fields), one per cell under test,
// delayed by guard plus reference cells; the request that carries frame_last
// flushes every remaining cell of the frame, newest bin last.
// Window shape (guard and reference counts) is latched on the first sample of a
// frame; threshold_scale and max_detections act at once. Registers are written
// through cfg_write, cfg_index and cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce this. A request that
// yields no verdict only stores its sample. Each verdict takes R + 1 reads of the
// window memory (two taps a cycle, one read port per side), R being the latched
// reference count, then an accumulate, a multiply and a compare step. The memory
// read ports set the verdict rate.
// Reset clears the frame position, detection count and result valid flag and
// restores the register defaults. When the receiver stalls, the finished verdict
// holds in the result register; the controller waits before loading the next one
// and keeps in_stall high until the request's last verdict is loaded.
module ca_cfar_detector_core #(
  parameter int MAX_REACH   = cacfar_pkg::MAX_REACH_DEF,
  parameter int MAX_POINTS  = cacfar_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = cacfar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [cacfar_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cacfar_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_BITS-1:0]               power,
  input  logic                                 frame_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(MAX_POINTS)-1:0]        bin_index,
  output logic                                 detected,
  output logic                                 dropped,
  output logic [cacfar_pkg::COUNT_W-1:0]       detection_count,
  output logic                                 frame_end
);

  localparam int OW = $clog2(2 * MAX_REACH + 1);
  localparam int BW = $clog2(MAX_POINTS);

  logic [cacfar_pkg::REACH_CFG_W-1:0] guard_cells;
  logic [cacfar_pkg::REACH_CFG_W-1:0] ref_cells;
  logic [cacfar_pkg::SCALE_W-1:0]     threshold_scale;
  logic [cacfar_pkg::COUNT_W-1:0]     max_detections;

  cacfar_pkg::dp_cmd_t cmd;
  logic [OW-1:0]       off_left, off_right;
  logic [BW-1:0]       cut_index;
  logic                out_free;

  // Register file; each register keeps the low bits of the written data.
  always_ff @(posedge clk) begin
    if (rst) begin
      guard_cells     <= cacfar_pkg::GUARD_RST;
      ref_cells       <= cacfar_pkg::REF_RST;
      threshold_scale <= cacfar_pkg::SCALE_RST;
      max_detections  <= cacfar_pkg::MAXDET_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        cacfar_pkg::CFG_GUARD:  guard_cells     <= cfg_data[cacfar_pkg::REACH_CFG_W-1:0];
        cacfar_pkg::CFG_REF:    ref_cells       <= cfg_data[cacfar_pkg::REACH_CFG_W-1:0];
        cacfar_pkg::CFG_SCALE:  threshold_scale <= cfg_data[cacfar_pkg::SCALE_W-1:0];
        cacfar_pkg::CFG_MAXDET: max_detections  <= cfg_data[cacfar_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  cacfar_ctrl #(
    .MAX_REACH  (MAX_REACH),
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_last  (frame_last),
    .guard_cells (guard_cells),
    .ref_cells   (ref_cells),
    .out_free    (out_free),
    .cmd         (cmd),
    .off_left    (off_left),
    .off_right   (off_right),
    .cut_index   (cut_index)
  );

  cacfar_dp #(
    .MAX_REACH   (MAX_REACH),
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .power           (power),
    .off_left        (off_left),
    .off_right       (off_right),
    .cut_index       (cut_index),
    .threshold_scale (threshold_scale),
    .max_detections  (max_detections),
    .out_free        (out_free),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .bin_index       (bin_index),
    .detected        (detected),
    .dropped         (dropped),
    .detection_count (detection_count),
    .frame_end       (frame_end)
  );

  // A verdict is only loaded when the result register can take it.
  a_judge_free: assert property (@(posedge clk) disable iff (rst)
    cmd.judge |-> (!out_valid || !out_stall))
    else $error("verdict loaded over an unaccepted result");

  // While the block takes requests, no verdict work is in flight.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(cmd.rd || cmd.mul || cmd.judge))
    else $error("verdict work while accepting requests");

  // The frame's closing verdict ends the flush.
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.judge && cmd.frame_end) |=> !in_stall)
    else $error("block still busy after the frame's closing verdict");

endmodule

// ===== sv/cacfar_ctrl.sv =====
// Controller of the CFAR detector: frame position, latched window shape and
// the sequence of tap reads, multiply and verdict for each cell under test.
// Depends on cacfar_pkg.
module cacfar_ctrl #(
  parameter int MAX_REACH  = cacfar_pkg::MAX_REACH_DEF,
  parameter int MAX_POINTS = cacfar_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  frame_last,
  input  logic [cacfar_pkg::REACH_CFG_W-1:0]    guard_cells,
  input  logic [cacfar_pkg::REACH_CFG_W-1:0]    ref_cells,
  input  logic                                  out_free,
  output cacfar_pkg::dp_cmd_t                   cmd,
  output logic [$clog2(2*MAX_REACH+1)-1:0]      off_left,
  output logic [$clog2(2*MAX_REACH+1)-1:0]      off_right,
  output logic [$clog2(MAX_POINTS)-1:0]         cut_index
);

  localparam int RW       = $clog2(MAX_REACH + 1);
  localparam int OW       = $clog2(2 * MAX_REACH + 1);
  localparam int SEEN_CAP = MAX_POINTS + 2 * MAX_REACH + 2;
  localparam int SW       = $clog2(SEEN_CAP + 1);
  localparam int BW       = $clog2(MAX_POINTS);
  localparam int CW       = (RW > cacfar_pkg::REACH_CFG_W) ? RW : cacfar_pkg::REACH_CFG_W;
  localparam logic [CW-1:0] REACH_C = CW'(MAX_REACH);
  localparam logic [SW-1:0] CAP_S   = SW'(SEEN_CAP);
  localparam logic [SW-1:0] BIN_MAX = SW'(MAX_POINTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_TAP, S_ACC, S_MUL, S_JUDGE} state_t;

  state_t        state;
  logic [SW-1:0] seen;
  logic [SW-1:0] cur_pos;
  logic [RW-1:0] lat_g;
  logic [RW-1:0] lat_r;
  logic [RW-1:0] c;
  logic [RW-1:0] t;
  logic          last_q;

  logic [CW-1:0] g_wide, r_room, r_wide;
  logic [RW-1:0] g_eff, r_eff, d_eff, start;
  logic          accept, reach_ok, go, done;
  logic [OW-1:0] c_o, g_o, t_o, left_off, right_reach;
  logic [SW-1:0] pos_diff;

  // Window shape: guard clipped to the reach, reference clipped to what remains.
  always_comb begin
    g_wide = (CW'(guard_cells) > REACH_C) ? REACH_C : CW'(guard_cells);
    r_room = REACH_C - g_wide;
    r_wide = (CW'(ref_cells) > r_room) ? r_room : CW'(ref_cells);
    g_eff  = (seen == '0) ? g_wide[RW-1:0] : lat_g;
    r_eff  = (seen == '0) ? r_wide[RW-1:0] : lat_r;
    d_eff  = g_eff + r_eff;
  end

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign reach_ok = (seen >= SW'(d_eff));
  assign go       = reach_ok || frame_last;
  assign start    = reach_ok ? d_eff : seen[RW-1:0];
  assign done     = !last_q || (c == '0);

  // Tap offsets, counted back from the newest sample.
  always_comb begin
    c_o         = OW'(c);
    g_o         = OW'(lat_g);
    t_o         = OW'(t);
    left_off    = c_o + g_o + t_o;
    right_reach = g_o + t_o;
    off_left    = (t == '0) ? c_o : left_off;
    off_right   = c_o - right_reach;
  end

  always_comb begin
    pos_diff  = cur_pos - SW'(c);
    cut_index = (pos_diff > BIN_MAX) ? BIN_MAX[BW-1:0] : pos_diff[BW-1:0];
  end

  always_comb begin
    cmd           = '0;
    cmd.push      = accept;
    cmd.rd        = (state == S_TAP);
    cmd.rd_first  = (t == '0);
    cmd.rd_left   = (t == '0) || (SW'(left_off) <= cur_pos);
    cmd.rd_right  = (t != '0) && (c_o >= right_reach);
    cmd.mul       = (state == S_MUL);
    cmd.judge     = (state == S_JUDGE) && out_free;
    cmd.frame_end = last_q && (c == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      seen    <= '0;
      cur_pos <= '0;
      lat_g   <= '0;
      lat_r   <= '0;
      c       <= '0;
      t       <= '0;
      last_q  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            lat_g   <= g_eff;
            lat_r   <= r_eff;
            cur_pos <= seen;
            if (frame_last) begin
              seen <= '0;
            end else if (seen < CAP_S) begin
              seen <= seen + SW'(1);
            end
            last_q <= frame_last;
            c      <= start;
            t      <= '0;
            if (go) begin
              state <= S_TAP;
            end
          end
        end
        S_TAP: begin
          if (t == lat_r) begin
            state <= S_ACC;
          end else begin
            t <= t + RW'(1);
          end
        end
        S_ACC: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_JUDGE;
        end
        S_JUDGE: begin
          if (out_free) begin
            if (done) begin
              state <= S_IDLE;
            end else begin
              c     <= c - RW'(1);
              t     <= '0;
              state <= S_TAP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/cacfar_dp.sv =====
// Datapath of the CFAR detector: sample window memory, reference sum
// accumulator, threshold products, compare, detection count and result register.
// Depends on cacfar_pkg.
module cacfar_dp #(
  parameter int MAX_REACH   = cacfar_pkg::MAX_REACH_DEF,
  parameter int MAX_POINTS  = cacfar_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = cacfar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cacfar_pkg::dp_cmd_t                 cmd,
  input  logic [SAMPLE_BITS-1:0]              power,
  input  logic [$clog2(2*MAX_REACH+1)-1:0]    off_left,
  input  logic [$clog2(2*MAX_REACH+1)-1:0]    off_right,
  input  logic [$clog2(MAX_POINTS)-1:0]       cut_index,
  input  logic [cacfar_pkg::SCALE_W-1:0]      threshold_scale,
  input  logic [cacfar_pkg::COUNT_W-1:0]      max_detections,
  output logic                                out_free,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [$clog2(MAX_POINTS)-1:0]       bin_index,
  output logic                                detected,
  output logic                                dropped,
  output logic [cacfar_pkg::COUNT_W-1:0]      detection_count,
  output logic                                frame_end
);

  localparam int AW    = $clog2(2 * MAX_REACH + 1);
  localparam int DEPTH = 2 ** AW;
  localparam int SB    = SAMPLE_BITS;
  localparam int SUM_W = SB + AW;
  localparam int PL_W  = SB + AW;
  localparam int PR_W  = cacfar_pkg::SCALE_W + SUM_W;
  localparam int CNT_W = cacfar_pkg::COUNT_W;

  logic [SB-1:0]    mem [DEPTH];
  logic [AW-1:0]    head;
  logic [SB-1:0]    rd_l, rd_r;
  logic             rd_q, first_q, left_q, right_q;
  logic [SB-1:0]    cut;
  logic [SUM_W-1:0] sum;
  logic [AW-1:0]    cnt;
  logic [PL_W-1:0]  prod_l;
  logic [PR_W-1:0]  prod_r;
  logic             cnt_nz;
  logic [CNT_W-1:0] kept;

  logic [SUM_W-1:0] add_l, add_r;
  logic [PR_W-1:0]  lhs;
  logic             above, under, hit;
  logic [CNT_W-1:0] kept_new;

  // Circular window: head points at the newest sample.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[head + AW'(1)] <= power;
    end
    rd_l <= mem[head - off_left];
    rd_r <= mem[head - off_right];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      rd_q <= 1'b0;
    end else begin
      if (cmd.push) begin
        head <= head + AW'(1);
      end
      rd_q <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    first_q <= cmd.rd_first;
    left_q  <= cmd.rd_left;
    right_q <= cmd.rd_right;
  end

  assign add_l = left_q ? SUM_W'(rd_l) : '0;
  assign add_r = right_q ? SUM_W'(rd_r) : '0;

  always_ff @(posedge clk) begin
    if (rd_q) begin
      if (first_q) begin
        cut <= rd_l;
        sum <= '0;
        cnt <= '0;
      end else begin
        sum <= sum + add_l + add_r;
        cnt <= cnt + AW'(left_q) + AW'(right_q);
      end
    end
    if (cmd.mul) begin
      prod_l <= PL_W'(cut) * PL_W'(cnt);
      prod_r <= PR_W'(threshold_scale) * PR_W'(sum);
      cnt_nz <= (cnt != '0);
    end
  end

  // power * cells * 256 against scale * sum; no reference cells means no hit.
  always_comb begin
    lhs      = PR_W'({prod_l, 8'b0});
    above    = cnt_nz && (lhs > prod_r);
    under    = (kept < max_detections);
    hit      = above && under;
    kept_new = kept + CNT_W'(hit);
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.judge) begin
        kept      <= cmd.frame_end ? '0 : kept_new;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      bin_index       <= cut_index;
      detected        <= hit;
      dropped         <= above && !under;
      detection_count <= kept_new;
      frame_end       <= cmd.frame_end;
    end
  end

endmodule
